>>> hdl/nes_bank_mapper_scanline_irq_top_assert.svh
// assertion macros for the bank mapper top level
`ifndef NES_BANK_MAPPER_SCANLINE_IRQ_TOP_ASSERT_SVH
`define NES_BANK_MAPPER_SCANLINE_IRQ_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define NBM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nbm assertion failed");

// next-cycle implication, checked outside reset
`define NBM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nbm assertion failed");

`endif

>>> hdl/nbm_pkg.sv
// types and constants for the bank mapper with scanline irq
`timescale 1ns / 1ps

package nbm_pkg;

  localparam int FUNC_W = 2;
  localparam int ADDR_W = 16;
  localparam int DATA_W = 8;
  localparam int MAP_W  = 18;
  localparam int BANK_W = 8;

  localparam int PROG_BANK_BITS    = 5;
  localparam int PATTERN_BANK_BITS = 8;

  localparam logic [BANK_W-1:0] PROG_MASK =
    BANK_W'((9'd1 << PROG_BANK_BITS) - 9'd1);
  localparam logic [BANK_W-1:0] PAT_MASK =
    BANK_W'((9'd1 << PATTERN_BANK_BITS) - 9'd1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE     = 2'd0,
    FUNC_TICK      = 2'd1,
    FUNC_XLATE_CPU = 2'd2,
    FUNC_XLATE_PPU = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    PAGE_PRG = 4'h8,
    PAGE_CHR = 4'hA,
    PAGE_IRQ = 4'hC,
    PAGE_MIR = 4'hD,
    PAGE_IEN = 4'hE
  } page_t;

  localparam logic [1:0] IRQ_SEL_RELOAD = 2'd1;
  localparam logic [1:0] IRQ_SEL_ARM    = 2'd3;
  localparam logic [1:0] SLOT_FIXED     = 2'd3;
  localparam logic [BANK_W-1:0] BANK_LAST = '1;

  localparam logic [BANK_W-1:0] PROG_RESET [4] = '{8'hFC, 8'hFD, 8'hFE, 8'hFF};

endpackage

>>> hdl/nes_bank_mapper_scanline_irq_top.sv
// Bank mapper with scanline irq counter. Takes one item per clock when the
// result side keeps up; each item is held in the input register and then
// written to the result register. Bank, mirroring and irq state change as
// an item moves from the input register to the result register, so items
// see the effect of all earlier items. irq_line and mirror_vertical give
// the state after the item; mapped_addr and addr_valid are zero for writes
// and ticks.
`timescale 1ns / 1ps

`include "nes_bank_mapper_scanline_irq_top_assert.svh"

module nes_bank_mapper_scanline_irq_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [nbm_pkg::FUNC_W-1:0] in_func,
  input  logic [nbm_pkg::ADDR_W-1:0] in_addr,
  input  logic [nbm_pkg::DATA_W-1:0] in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [nbm_pkg::MAP_W-1:0] out_mapped_addr,
  output logic                      out_addr_valid,
  output logic                      out_irq_line,
  output logic                      out_mirror_vertical
);
  import nbm_pkg::*;

  // input register
  logic              s1_valid_r;
  func_t             s1_func_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [DATA_W-1:0] s1_data_r;

  // mapper state
  logic [BANK_W-1:0] prog_bank_r [4];
  logic [BANK_W-1:0] prog_bank_nxt [4];
  logic [BANK_W-1:0] pattern_bank_r [8];
  logic [BANK_W-1:0] pattern_bank_nxt [8];
  logic              mirror_bit_r, mirror_bit_nxt;
  logic              irq_enable_r, irq_enable_nxt;
  logic              irq_armed_r, irq_armed_nxt;
  logic [7:0]        irq_count_r, irq_count_nxt;
  logic [7:0]        irq_reload_r, irq_reload_nxt;
  logic              irq_pending_r, irq_pending_nxt;

  // result register
  logic              out_valid_r;
  logic [MAP_W-1:0]  mapped_r, mapped_nxt;
  logic              addr_valid_r, addr_valid_nxt;

  logic              in_acc;
  logic              s1_adv;
  logic [3:0]        page;
  logic [1:0]        slot;
  logic [BANK_W-1:0] cpu_bank;
  logic [BANK_W-1:0] ppu_bank;
  logic [BANK_W+12:0] cpu_off;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  assign page = s1_addr_r[15:12];
  assign slot = s1_addr_r[14:13];

  assign cpu_bank = ((slot == SLOT_FIXED) ? BANK_LAST : prog_bank_r[slot]) & PROG_MASK;
  assign ppu_bank = pattern_bank_r[s1_addr_r[12:10]] & PAT_MASK;
  assign cpu_off  = {cpu_bank, s1_addr_r[12:0]};

  always_comb begin
    prog_bank_nxt    = prog_bank_r;
    pattern_bank_nxt = pattern_bank_r;
    mirror_bit_nxt   = mirror_bit_r;
    irq_enable_nxt   = irq_enable_r;
    irq_armed_nxt    = irq_armed_r;
    irq_count_nxt    = irq_count_r;
    irq_reload_nxt   = irq_reload_r;
    irq_pending_nxt  = irq_pending_r;
    mapped_nxt       = '0;
    addr_valid_nxt   = 1'b0;
    case (s1_func_r)
      FUNC_WRITE: begin
        case (page)
          PAGE_PRG: prog_bank_nxt[s1_addr_r[1:0]] = s1_data_r;
          PAGE_CHR: begin
            if (!s1_addr_r[3]) begin
              pattern_bank_nxt[s1_addr_r[2:0]] = s1_data_r;
            end
          end
          PAGE_IRQ: begin
            if (s1_addr_r[1:0] == IRQ_SEL_RELOAD) begin
              irq_reload_nxt = s1_data_r;
            end else if (s1_addr_r[1:0] == IRQ_SEL_ARM) begin
              irq_count_nxt = irq_reload_r;
              irq_armed_nxt = 1'b1;
            end
            irq_pending_nxt = 1'b0;
          end
          PAGE_MIR: mirror_bit_nxt = s1_data_r[0];
          PAGE_IEN: begin
            irq_enable_nxt  = s1_data_r[0];
            irq_pending_nxt = 1'b0;
          end
          default: ;
        endcase
      end
      FUNC_TICK: begin
        if (irq_enable_r && irq_armed_r && (irq_count_r != 8'd0)) begin
          irq_count_nxt = irq_count_r - 8'd1;
          if (irq_count_r == 8'd1) begin
            irq_armed_nxt   = 1'b0;
            irq_pending_nxt = 1'b1;
          end
        end
      end
      FUNC_XLATE_CPU: begin
        if (s1_addr_r[15]) begin
          mapped_nxt     = cpu_off[MAP_W-1:0];
          addr_valid_nxt = 1'b1;
        end
      end
      FUNC_XLATE_PPU: begin
        if (s1_addr_r[15:13] == 3'd0) begin
          mapped_nxt     = {ppu_bank, s1_addr_r[9:0]};
          addr_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r <= func_t'(in_func);
      s1_addr_r <= in_addr;
      s1_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_bank_r    <= PROG_RESET;
      pattern_bank_r <= '{default: '0};
      mirror_bit_r   <= 1'b0;
      irq_enable_r   <= 1'b0;
      irq_armed_r    <= 1'b0;
      irq_count_r    <= '0;
      irq_reload_r   <= '0;
      irq_pending_r  <= 1'b0;
    end else if (s1_adv) begin
      prog_bank_r    <= prog_bank_nxt;
      pattern_bank_r <= pattern_bank_nxt;
      mirror_bit_r   <= mirror_bit_nxt;
      irq_enable_r   <= irq_enable_nxt;
      irq_armed_r    <= irq_armed_nxt;
      irq_count_r    <= irq_count_nxt;
      irq_reload_r   <= irq_reload_nxt;
      irq_pending_r  <= irq_pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      mapped_r     <= mapped_nxt;
      addr_valid_r <= addr_valid_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_mapped_addr     = mapped_r;
  assign out_addr_valid      = addr_valid_r;
  assign out_irq_line        = irq_pending_r;
  assign out_mirror_vertical = ~mirror_bit_r;

  // last counted scanline raises the irq
  `NBM_ASSERT_NEXT(a_irq_on_last_tick,
    s1_adv && (s1_func_r == FUNC_TICK) && irq_enable_r && irq_armed_r &&
      (irq_count_r == 8'd1),
    irq_pending_r && !irq_armed_r)

  // the irq only rises on a tick
  `NBM_ASSERT_NOW(a_irq_rise_from_tick,
    $rose(irq_pending_r),
    $past(s1_adv) && ($past(s1_func_r) == FUNC_TICK))

  // untranslated items carry a zero offset
  `NBM_ASSERT_NOW(a_zero_when_unmapped,
    out_valid_r && !addr_valid_r,
    mapped_r == '0)

endmodule
